FILE: rtl/iprt_pkg.sv
`default_nettype none

package iprt_pkg;

  // Default table depth
  localparam int unsigned ROUTE_ENTRIES_DEF = 16;

  // Field widths
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned IFACE_W = 8;
  localparam int unsigned ENTRY_W = 2 * ADDR_W + IFACE_W;

  // Item kinds
  typedef enum logic {
    KIND_ADD    = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_NOMATCH = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic rd_en;
    logic out_load;
  } iprt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic scan_last;
    logic out_busy;
  } iprt_sts_t;

endpackage

`default_nettype wire

FILE: rtl/iprt_if.sv
`default_nettype none

// Request channel: one add or lookup item per transfer
interface iprt_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] route_prefix;
  logic [31:0] route_mask;
  logic [7:0]  route_iface;
  logic [31:0] lookup_addr;

  modport source (
    output valid, kind, route_prefix, route_mask, route_iface, lookup_addr,
    input  ready
  );
  modport sink (
    input  valid, kind, route_prefix, route_mask, route_iface, lookup_addr,
    output ready
  );
endinterface

// Result channel: one status and interface index per transfer
interface iprt_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] out_iface;

  modport source (
    output valid, status, out_iface,
    input  ready
  );
  modport sink (
    input  valid, status, out_iface,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/iprt_ram.sv
`default_nettype none

module iprt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/iprt_ctrl.sv
`default_nettype none

module iprt_ctrl
  import iprt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_kind,
  output logic           in_ready,
  input  wire iprt_sts_t sts,
  output iprt_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence one item: take it, scan the table if needed, hand on the result
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.rd_en    = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (kind_t'(in_kind) == KIND_LOOKUP && !sts.empty) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/iprt_dp.sv
`default_nettype none

module iprt_dp
  import iprt_pkg::*;
#(
  parameter int unsigned ROUTE_ENTRIES = ROUTE_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire iprt_cmd_t          cmd,
  output iprt_sts_t               sts,
  input  wire logic               in_kind,
  input  wire logic [ADDR_W-1:0]  in_route_prefix,
  input  wire logic [ADDR_W-1:0]  in_route_mask,
  input  wire logic [IFACE_W-1:0] in_route_iface,
  input  wire logic [ADDR_W-1:0]  in_lookup_addr,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [IFACE_W-1:0]      out_iface
);

  localparam int unsigned AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ROUTE_ENTRIES + 1);

  logic [CW-1:0]      count_r;
  logic [AW-1:0]      idx_r;
  logic               kind_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [1:0]         add_status_r;
  logic               cmp_vld_r;
  logic               found_r;
  logic [ADDR_W-1:0]  top_mask_r;
  logic [IFACE_W-1:0] best_iface_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [IFACE_W-1:0] out_iface_r;

  logic               full;
  logic               add_wr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;
  logic [ADDR_W-1:0]  ent_prefix;
  logic [ADDR_W-1:0]  ent_mask;
  logic [IFACE_W-1:0] ent_iface;
  logic               hit;

  assign full    = (count_r == CW'(ROUTE_ENTRIES));
  assign add_wr  = cmd.accept && (kind_t'(in_kind) == KIND_ADD) && !full;
  assign wr_data = {in_route_prefix, in_route_mask, in_route_iface};

  iprt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ROUTE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (add_wr),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  assign ent_prefix = rd_data[ENTRY_W-1 -: ADDR_W];
  assign ent_mask   = rd_data[IFACE_W +: ADDR_W];
  assign ent_iface  = rd_data[IFACE_W-1:0];

  // Later entries win ties, so the compare takes equal masks
  assign hit = ((addr_r & ent_mask) == ent_prefix) && (ent_mask >= top_mask_r);

  // Fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (add_wr) begin
      count_r <= count_r + CW'(1);
    end
  end

  // Latch the item and its add status
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r       <= in_kind;
      addr_r       <= in_lookup_addr;
      add_status_r <= full ? STS_FULL : STS_OK;
    end
  end

  // Walk the filled entries, one read a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.rd_en;
      if (cmd.accept) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end else begin
        if (cmd.rd_en) begin
          idx_r <= idx_r + AW'(1);
        end
        if (cmp_vld_r && hit) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  // Keep the best match so far
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      top_mask_r   <= '0;
      best_iface_r <= '0;
    end else if (cmp_vld_r && hit) begin
      top_mask_r   <= ent_mask;
      best_iface_r <= ent_iface;
    end
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (kind_t'(kind_r) == KIND_ADD) begin
        out_status_r <= add_status_r;
        out_iface_r  <= '0;
      end else if (found_r) begin
        out_status_r <= STS_OK;
        out_iface_r  <= best_iface_r;
      end else begin
        out_status_r <= STS_NOMATCH;
        out_iface_r  <= '0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_iface  = out_iface_r;

  assign sts.empty     = (count_r == '0);
  assign sts.scan_last = ((CW'(idx_r) + CW'(1)) == count_r);
  assign sts.out_busy  = out_valid_r && !out_ready;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ROUTE_ENTRIES))
    else $error("route count beyond table depth");

  a_read_filled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (CW'(idx_r) < count_r))
    else $error("scan reads an unfilled entry");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    add_wr |=> (count_r == $past(count_r) + CW'(1)))
    else $error("accepted add did not grow the table");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

FILE: rtl/ipv4_route_table_prefix_match_unit.sv
`default_nettype none

// IPv4 route table with longest-mask lookup.
// in_ch carries one item per transfer: kind 0 appends a route (prefix, mask,
// interface) or reports full; kind 1 resolves lookup_addr against filled routes.
// out_ch returns exactly one status and interface index per item, in order.
// An add, or a lookup on an empty table, goes from idle straight to done; a
// lookup over filled routes passes idle, scan, drain and done, the scan paced
// by the single read port of the route RAM, one entry per cycle.
// The block takes one item at a time; in_ch.ready is high only between
// items, while the controller is idle.
// A finished result sits in the output register until transfer; the next
// item is taken meanwhile and its result waits until the register frees.
// Reset (rst_n low, synchronous) empties the table and drops any result;
// the route RAM itself is not cleared, as only filled entries are read.

module ipv4_route_table_prefix_match_unit
  import iprt_pkg::*;
#(
  parameter int unsigned ROUTE_ENTRIES = ROUTE_ENTRIES_DEF
) (
  input wire logic     clk,
  input wire logic     rst_n,
  iprt_req_if.sink     in_ch,
  iprt_rsp_if.source   out_ch
);

  iprt_cmd_t cmd;
  iprt_sts_t sts;

  iprt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  iprt_dp #(
    .ROUTE_ENTRIES (ROUTE_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_ch.kind),
    .in_route_prefix (in_ch.route_prefix),
    .in_route_mask   (in_ch.route_mask),
    .in_route_iface  (in_ch.route_iface),
    .in_lookup_addr  (in_ch.lookup_addr),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_iface       (out_ch.out_iface)
  );

endmodule

`default_nettype wire
